// File: rtl/io_sample_packet_parser_defines.svh
// ============================================================================
// Assertion macros for the I/O sample packet parser
// Clocked assertion wrappers that vanish in synthesis builds.
// ============================================================================
`ifndef IO_SAMPLE_PACKET_PARSER_DEFINES_SVH
`define IO_SAMPLE_PACKET_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// Concurrent assertion of a property, disabled while reset is asserted.
`define ISP_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Concurrent assertion that a condition never holds.
`define ISP_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
    `ISP_ASSERT(name, clk, rst_n, !(cond), msg)
`else
`define ISP_ASSERT(name, clk, rst_n, prop, msg)
`define ISP_ASSERT_NEVER(name, clk, rst_n, cond, msg)
`endif

`endif

// File: rtl/isp_pkg.sv
// ============================================================================
// isp_pkg
// Shared constants and types of the I/O sample packet parser.
// ============================================================================
package isp_pkg;

    // Configuration defaults of the top level.
    localparam int DEFAULT_CHANNELS            = 8;
    localparam int DEFAULT_SAMPLE_BUFFER_BYTES = 32;

    // Packet layout.
    localparam int          MAX_CHANNELS = 8;
    localparam int          HEADER_BYTES = 12;
    localparam int          POS_W        = 6;
    localparam logic [15:0] CHECK_MAGIC  = 16'h4242;

    // Temperature conversion.
    localparam int FULL_SCALE    = 1023;
    localparam int OFFSET_TENTHS = 500;
    localparam int TENTHS_MAX    = 262143;

    // Queue sizes.
    localparam int JQ_DEPTH = 2;
    localparam int JQ_AW    = $clog2(JQ_DEPTH);
    localparam int OQ_DEPTH = 8;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);

    // Configuration port.
    localparam int                     CFG_INDEX_W        = 2;
    localparam int                     CFG_DATA_W         = 13;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REFERENCE_MV   = 2'd1;
    localparam logic [7:0]             ENABLE_RESET       = 8'd3;
    localparam logic [12:0]            REFERENCE_RESET    = 13'd2500;

    // One unit of work for the back end: a run of channels to emit.
    typedef struct packed {
        logic [MAX_CHANNELS-1:0] mask;
        logic [3:0]              slot;
        logic [15:0]             raw;
        logic                    pad;
        logic                    header_ok;
    } job_t;

    // One result item.
    typedef struct packed {
        logic [2:0]         channel;
        logic [3:0]         slot;
        logic [15:0]        raw;
        logic signed [18:0] tenths;
        logic               conv;
        logic               header_ok;
        logic               pad;
        logic               last;
    } result_t;

endpackage

// File: rtl/isp_front.sv
// ============================================================================
// isp_front
// Byte parser: tracks the header and sample positions and turns each
// accepted byte into at most one job for the back end.
// ============================================================================
`include "io_sample_packet_parser_defines.svh"

module isp_front #(
    parameter int CHANNELS            = isp_pkg::DEFAULT_CHANNELS,
    parameter int SAMPLE_BUFFER_BYTES = isp_pkg::DEFAULT_SAMPLE_BUFFER_BYTES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          packet_byte,
    input  logic                end_of_packet,
    output logic                job_push,
    output isp_pkg::job_t       job
);

    localparam logic [isp_pkg::POS_W-1:0] POS_LIMIT =
        isp_pkg::POS_W'(isp_pkg::HEADER_BYTES + SAMPLE_BUFFER_BYTES);
    localparam logic [isp_pkg::POS_W-1:0] POS_CHECK_A_LO  = 6'd0;
    localparam logic [isp_pkg::POS_W-1:0] POS_CHECK_A_HI  = 6'd1;
    localparam logic [isp_pkg::POS_W-1:0] POS_CHECK_B_LO  = 6'd2;
    localparam logic [isp_pkg::POS_W-1:0] POS_CHECK_B_HI  = 6'd3;
    localparam logic [isp_pkg::POS_W-1:0] POS_DIGITAL_HI  = 6'd9;
    localparam logic [isp_pkg::POS_W-1:0] POS_DIGITAL_LO  = 6'd10;
    localparam logic [isp_pkg::POS_W-1:0] POS_ANALOG_MASK = 6'd11;
    localparam logic [isp_pkg::POS_W-1:0] POS_SAMPLES     =
        isp_pkg::POS_W'(isp_pkg::HEADER_BYTES);
    localparam logic [isp_pkg::POS_W-1:0] POS_AFTER_DIG   =
        isp_pkg::POS_W'(isp_pkg::HEADER_BYTES + 2);

    logic [isp_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [15:0]               check_a_reg, check_a_next;
    logic [15:0]               xor_reg, xor_next;
    logic                      digital_reg, digital_next;
    logic [CHANNELS-1:0]       mask_reg, mask_next;
    logic [7:0]                pending_reg, pending_next;
    logic [3:0]                slot_reg, slot_next;

    logic                      half;
    logic                      normal;
    logic [CHANNELS-1:0]       mask_eff;
    logic [CHANNELS-1:0]       lowest;
    logic [3:0]                slot_eff;
    logic                      header_ok;

    // Parse one byte and build its job.
    always_comb
    begin
        pos_next     = pos_reg;
        check_a_next = check_a_reg;
        xor_next     = xor_reg;
        digital_next = digital_reg;
        mask_next    = mask_reg;
        pending_next = pending_reg;
        slot_next    = slot_reg;
        half         = 1'b0;
        normal       = 1'b0;
        job_push     = 1'b0;
        job          = '0;

        if (pos_reg < POS_LIMIT)
        begin
            pos_next = pos_reg + 1'b1;
            if (pos_reg == POS_CHECK_A_LO)
            begin
                check_a_next = {8'h00, packet_byte};
            end
            else if (pos_reg == POS_CHECK_A_HI)
            begin
                check_a_next = {packet_byte, check_a_reg[7:0]};
            end
            else if (pos_reg == POS_CHECK_B_LO)
            begin
                xor_next = {8'h00, check_a_reg[7:0] ^ packet_byte};
            end
            else if (pos_reg == POS_CHECK_B_HI)
            begin
                xor_next = {check_a_reg[15:8] ^ packet_byte, xor_reg[7:0]};
            end
            else if (pos_reg == POS_DIGITAL_HI || pos_reg == POS_DIGITAL_LO)
            begin
                if (packet_byte != 8'h00)
                begin
                    digital_next = 1'b1;
                end
            end
            else if (pos_reg == POS_ANALOG_MASK)
            begin
                mask_next = packet_byte[CHANNELS-1:0];
                slot_next = {3'b000, digital_reg};
            end
            else if (pos_reg >= POS_SAMPLES)
            begin
                // The digital sample occupies the first two sample bytes.
                if (!(digital_reg && pos_reg < POS_AFTER_DIG) && mask_reg != '0)
                begin
                    if (!pos_reg[0])
                    begin
                        pending_next = packet_byte;
                        half         = 1'b1;
                    end
                    else
                    begin
                        normal = 1'b1;
                    end
                end
            end
        end

        mask_eff  = mask_next;
        slot_eff  = slot_next;
        lowest    = mask_eff & (~mask_eff + 1'b1);
        header_ok = (xor_next == isp_pkg::CHECK_MAGIC);

        if (normal)
        begin
            mask_next = mask_eff & ~lowest;
            slot_next = slot_eff + 1'b1;
        end

        job.slot      = slot_eff;
        job.header_ok = header_ok;
        if (end_of_packet)
        begin
            // Early end: every pending channel goes out in one run.
            job_push           = accept && (mask_eff != '0);
            job.mask[CHANNELS-1:0] = mask_eff;
            job.pad            = !normal;
            if (normal)
            begin
                job.raw = {pending_reg, packet_byte};
            end
            else if (half)
            begin
                job.raw = {packet_byte, 8'h00};
            end
            else
            begin
                job.raw = 16'h0000;
            end
            pos_next     = '0;
            check_a_next = '0;
            xor_next     = '0;
            digital_next = 1'b0;
            mask_next    = '0;
            pending_next = '0;
            slot_next    = '0;
        end
        else
        begin
            job_push           = accept && normal;
            job.mask[CHANNELS-1:0] = lowest;
            job.raw            = {pending_reg, packet_byte};
            job.pad            = 1'b0;
        end
    end

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            check_a_reg <= '0;
            xor_reg     <= '0;
            digital_reg <= 1'b0;
            mask_reg    <= '0;
            pending_reg <= '0;
            slot_reg    <= '0;
        end
        else if (accept)
        begin
            pos_reg     <= pos_next;
            check_a_reg <= check_a_next;
            xor_reg     <= xor_next;
            digital_reg <= digital_next;
            mask_reg    <= mask_next;
            pending_reg <= pending_next;
            slot_reg    <= slot_next;
        end
    end

    `ISP_ASSERT(a_eop_restarts, clk, rst_n, (accept && end_of_packet) |=> (pos_reg == '0), "packet end did not restart the parser")

endmodule

// File: rtl/isp_job_queue.sv
// ============================================================================
// isp_job_queue
// Short queue of jobs between the parser and the result engine.
// ============================================================================
module isp_job_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  isp_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output isp_pkg::job_t head
);

    isp_pkg::job_t                mem [isp_pkg::JQ_DEPTH];
    logic [isp_pkg::JQ_AW-1:0]    wr_ptr_reg;
    logic [isp_pkg::JQ_AW-1:0]    rd_ptr_reg;
    logic [isp_pkg::JQ_AW:0]      count_reg, count_next;

    assign full      = (count_reg == (isp_pkg::JQ_AW+1)'(isp_pkg::JQ_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    // Occupancy.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Job storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: rtl/isp_back.sv
// ============================================================================
// isp_back
// Result engine: walks each job's channel run, converts enabled channels
// to tenths of a degree and holds finished results in an output queue.
// ============================================================================
`include "io_sample_packet_parser_defines.svh"

module isp_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [7:0]                 channel_enable,
    input  logic [12:0]                reference_mv,
    input  logic                       job_valid,
    input  isp_pkg::job_t              job,
    output logic                       job_pop,
    input  logic                       pop,
    output logic                       empty,
    output isp_pkg::result_t           result
);

    localparam logic signed [20:0] SAT_HI = 21'(isp_pkg::TENTHS_MAX);
    localparam logic signed [20:0] OFFSET = 21'(isp_pkg::OFFSET_TENTHS);

    // Active job.
    logic                             act_valid_reg;
    logic [isp_pkg::MAX_CHANNELS-1:0] act_mask_reg;
    logic [3:0]                       act_slot_reg;
    logic [15:0]                      act_raw_reg;
    logic                             act_pad_reg;
    logic                             act_hok_reg;

    logic                             issue;
    logic                             load;
    logic                             last;
    logic [isp_pkg::MAX_CHANNELS-1:0] lowest;
    logic [2:0]                       channel;
    logic [isp_pkg::OQ_AW:0]          reserved_reg, reserved_next;
    logic                             out_take;

    // Conversion pipeline.
    logic                             s1_v_reg, s2_v_reg, s3_v_reg;
    isp_pkg::result_t                 s1_reg, s2_reg, s3_reg;
    logic [28:0]                      s1_prod_reg, s2_prod_reg;
    logic [29:0]                      quot_sum;
    logic [19:0]                      s2_q0_reg, s3_q_reg;
    logic [29:0]                      remainder;
    logic [19:0]                      quot;
    logic signed [20:0]               diff;
    isp_pkg::result_t                 finished;

    // Output queue.
    isp_pkg::result_t                 oq_mem [isp_pkg::OQ_DEPTH];
    logic [isp_pkg::OQ_AW-1:0]        oq_wr_reg, oq_rd_reg;
    logic [isp_pkg::OQ_AW:0]          oq_count_reg, oq_count_next;

    // Pick the lowest pending channel of the run.
    always_comb
    begin
        channel = 3'd0;
        for (int i = isp_pkg::MAX_CHANNELS - 1; i >= 0; i--)
        begin
            if (act_mask_reg[i])
            begin
                channel = 3'(i);
            end
        end
    end

    assign lowest   = act_mask_reg & (~act_mask_reg + 1'b1);
    assign last     = ((act_mask_reg & ~lowest) == '0);
    assign issue    = act_valid_reg && (reserved_reg < (isp_pkg::OQ_AW+1)'(isp_pkg::OQ_DEPTH));
    assign load     = job_valid && (!act_valid_reg || (issue && last));
    assign job_pop  = load;
    assign out_take = pop && !empty;

    // Run sequencer: one channel per cycle given queue room; later ones pad.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            act_valid_reg <= 1'b1;
        end
        else if (issue && last)
        begin
            act_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            act_mask_reg <= job.mask;
            act_slot_reg <= job.slot;
            act_raw_reg  <= job.raw;
            act_pad_reg  <= job.pad;
            act_hok_reg  <= job.header_ok;
        end
        else if (issue)
        begin
            act_mask_reg <= act_mask_reg & ~lowest;
            act_slot_reg <= act_slot_reg + 1'b1;
            act_raw_reg  <= 16'h0000;
            act_pad_reg  <= 1'b1;
        end
    end

    // Output queue space held by items in flight or waiting.
    always_comb
    begin
        reserved_next = reserved_reg;
        if (issue && !out_take)
        begin
            reserved_next = reserved_reg + 1'b1;
        end
        else if (out_take && !issue)
        begin
            reserved_next = reserved_reg - 1'b1;
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reserved_reg <= '0;
            s1_v_reg     <= 1'b0;
            s2_v_reg     <= 1'b0;
            s3_v_reg     <= 1'b0;
        end
        else
        begin
            reserved_reg <= reserved_next;
            s1_v_reg     <= issue;
            s2_v_reg     <= s1_v_reg;
            s3_v_reg     <= s2_v_reg;
        end
    end

    // Stage one: product of sample and reference.
    always_ff @(posedge clk)
    begin
        s1_reg.channel   <= channel;
        s1_reg.slot      <= act_slot_reg;
        s1_reg.raw       <= act_raw_reg;
        s1_reg.tenths    <= '0;
        s1_reg.conv      <= channel_enable[channel];
        s1_reg.header_ok <= act_hok_reg;
        s1_reg.pad       <= act_pad_reg;
        s1_reg.last      <= last;
        s1_prod_reg      <= act_raw_reg * reference_mv;
    end

    // Stage two: quotient estimate, p/1023 as p/1024 * (1 + 2^-10 + 2^-20).
    assign quot_sum = 30'(s1_prod_reg) + 30'(s1_prod_reg >> 10) + 30'(s1_prod_reg >> 20);

    always_ff @(posedge clk)
    begin
        s2_reg      <= s1_reg;
        s2_prod_reg <= s1_prod_reg;
        s2_q0_reg   <= quot_sum[29:10];
    end

    // Stage three: the estimate is low by at most one, fix it up.
    assign remainder = 30'(s2_prod_reg) - {s2_q0_reg, 10'b0} + 30'(s2_q0_reg);
    assign quot      = (remainder >= 30'(isp_pkg::FULL_SCALE)) ? s2_q0_reg + 1'b1 : s2_q0_reg;

    always_ff @(posedge clk)
    begin
        s3_reg   <= s2_reg;
        s3_q_reg <= quot;
    end

    // Remove the offset and saturate.
    assign diff = $signed({1'b0, s3_q_reg}) - OFFSET;

    always_comb
    begin
        finished = s3_reg;
        if (!s3_reg.conv)
        begin
            finished.tenths = '0;
        end
        else if (diff > SAT_HI)
        begin
            finished.tenths = SAT_HI[18:0];
        end
        else
        begin
            finished.tenths = diff[18:0];
        end
    end

    // Output queue.
    always_comb
    begin
        oq_count_next = oq_count_reg;
        if (s3_v_reg && !out_take)
        begin
            oq_count_next = oq_count_reg + 1'b1;
        end
        else if (out_take && !s3_v_reg)
        begin
            oq_count_next = oq_count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg    <= '0;
            oq_rd_reg    <= '0;
            oq_count_reg <= '0;
        end
        else
        begin
            oq_count_reg <= oq_count_next;
            if (s3_v_reg)
            begin
                oq_wr_reg <= oq_wr_reg + 1'b1;
            end
            if (out_take)
            begin
                oq_rd_reg <= oq_rd_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_v_reg)
        begin
            oq_mem[oq_wr_reg] <= finished;
        end
    end

    assign empty  = (oq_count_reg == '0);
    assign result = oq_mem[oq_rd_reg];

    `ISP_ASSERT_NEVER(a_reserve_bound, clk, rst_n, reserved_reg > (isp_pkg::OQ_AW+1)'(isp_pkg::OQ_DEPTH), "output space over-reserved")
    `ISP_ASSERT_NEVER(a_oq_overflow, clk, rst_n, s3_v_reg && !out_take && oq_count_reg == (isp_pkg::OQ_AW+1)'(isp_pkg::OQ_DEPTH), "result written into a full output queue")
    `ISP_ASSERT(a_active_run, clk, rst_n, act_valid_reg |-> (act_mask_reg != '0), "active run has no channel left")

endmodule

// File: rtl/io_sample_packet_parser.sv
// ============================================================================
// io_sample_packet_parser
// Sensor I/O sample packet parser with temperature conversion.
// ============================================================================
// Takes one packet byte per cycle whenever full is low. A byte that completes
// an analog sample yields one result via the job queue, the active run and
// the conversion stages; a final byte that cuts the packet short yields one
// result per channel still pending (up to eight), issued one per cycle while
// output space is free, as the parser keeps taking bytes into its two-entry
// job queue. The conversion is a three-stage pipeline (multiply, reciprocal
// estimate of /1023, one-step fix-up); an eight-entry output queue decouples
// the result side, so sustained throughput is one item per cycle when popped.
module io_sample_packet_parser #(
    parameter int CHANNELS            = isp_pkg::DEFAULT_CHANNELS,
    parameter int SAMPLE_BUFFER_BYTES = isp_pkg::DEFAULT_SAMPLE_BUFFER_BYTES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Byte input
    input  logic                            push,
    output logic                            full,
    input  logic [7:0]                      packet_byte,
    input  logic                            end_of_packet,
    // Results
    output logic                            empty,
    input  logic                            pop,
    output logic [2:0]                      channel,
    output logic [3:0]                      sample_slot,
    output logic [15:0]                     raw_value,
    output logic signed [18:0]              celsius_tenths,
    output logic                            converted,
    output logic                            header_ok,
    output logic                            padded,
    output logic                            last_of_run,
    // Configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [isp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [isp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic [7:0]        enable_reg;
    logic [12:0]       reference_reg;
    logic              accept;
    logic              job_push;
    isp_pkg::job_t     front_job;
    logic              jq_full;
    logic              jq_pop;
    logic              jq_not_empty;
    isp_pkg::job_t     jq_head;
    isp_pkg::result_t  result;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= isp_pkg::ENABLE_RESET;
            reference_reg <= isp_pkg::REFERENCE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                isp_pkg::CFG_CHANNEL_ENABLE: enable_reg    <= cfg_data[7:0];
                isp_pkg::CFG_REFERENCE_MV:   reference_reg <= cfg_data[12:0];
                default:                     ;
            endcase
        end
    end

    // Input handshake.
    assign full   = jq_full;
    assign accept = push && !jq_full;

    isp_front #(
        .CHANNELS            (CHANNELS),
        .SAMPLE_BUFFER_BYTES (SAMPLE_BUFFER_BYTES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .packet_byte   (packet_byte),
        .end_of_packet (end_of_packet),
        .job_push      (job_push),
        .job           (front_job)
    );

    isp_job_queue u_job_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_job  (front_job),
        .full      (jq_full),
        .pop       (jq_pop),
        .not_empty (jq_not_empty),
        .head      (jq_head)
    );

    isp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .channel_enable (enable_reg),
        .reference_mv   (reference_reg),
        .job_valid      (jq_not_empty),
        .job            (jq_head),
        .job_pop        (jq_pop),
        .pop            (pop),
        .empty          (empty),
        .result         (result)
    );

    // Result fields.
    assign channel        = result.channel;
    assign sample_slot    = result.slot;
    assign raw_value      = result.raw;
    assign celsius_tenths = result.tenths;
    assign converted      = result.conv;
    assign header_ok      = result.header_ok;
    assign padded         = result.pad;
    assign last_of_run    = result.last;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the I/O sample packet parser
// Sends whole packets one byte at a time (good and bad headers, digital
// samples, early ends, overlong packets) under several converter settings.
// Every accepted byte runs through a local model of the parser. The readings
// it yields are queued and checked field by field against the result port.
// ----------------------------------------------------------------------------
module testbench;
    import isp_pkg::*;

    localparam int BUFFER_BYTES = DEFAULT_SAMPLE_BUFFER_BYTES;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT = 300000;

    // One byte of a packet as the sender queues it.
    typedef struct packed {
        logic [7:0] value;
        logic       eop;
    } packet_item_t;

    // One reading as the result port shows it.
    typedef struct packed {
        logic [2:0]         channel;
        logic [3:0]         slot;
        logic [15:0]        raw;
        logic signed [18:0] tenths;
        logic               conv;
        logic               header_ok;
        logic               pad;
        logic               last;
    } reading_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   push = 1'b0;
    logic                   full;
    logic [7:0]             packet_byte = 8'h00;
    logic                   end_of_packet = 1'b0;
    logic                   empty;
    logic                   pop = 1'b0;
    logic [2:0]             channel;
    logic [3:0]             sample_slot;
    logic [15:0]            raw_value;
    logic signed [18:0]     celsius_tenths;
    logic                   converted;
    logic                   header_ok;
    logic                   padded;
    logic                   last_of_run;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_CHANNEL_ENABLE;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    io_sample_packet_parser u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .packet_byte    (packet_byte),
        .end_of_packet  (end_of_packet),
        .empty          (empty),
        .pop            (pop),
        .channel        (channel),
        .sample_slot    (sample_slot),
        .raw_value      (raw_value),
        .celsius_tenths (celsius_tenths),
        .converted      (converted),
        .header_ok      (header_ok),
        .padded         (padded),
        .last_of_run    (last_of_run),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #6 clk = ~clk;

    // Converter settings as last written.
    logic [7:0]  chan_en = ENABLE_RESET;
    logic [12:0] ref_mv = REFERENCE_RESET;

    // Parser state.
    logic [5:0]  byte_pos = '0;
    logic [15:0] first_word = '0;
    logic [15:0] chk_xor = '0;
    logic        dig_present = 1'b0;
    logic [7:0]  mask_left = '0;
    logic [7:0]  hi_byte = '0;
    logic [3:0]  slot = '0;

    packet_item_t bytes_to_send[$];
    reading_t     readings_due[$];
    reading_t     due;
    int           mismatches = 0;
    int           bytes_queued = 0;
    int           burst_left = 1;
    int           gap_left = 0;
    logic [15:0]  pop_pattern = 16'hFFFF;
    int           pattern_left = 0;
    int           cycles = 0;

    // Emits the reading of the lowest pending channel.
    task automatic emit_reading(input logic [15:0] raw, input logic pad);
        int       ch;
        longint   t;
        reading_t r;
        ch = 0;
        for (int i = MAX_CHANNELS - 1; i >= 0; i--)
            if (mask_left[i])
                ch = i;
        mask_left[ch] = 1'b0;
        t = 0;
        if (chan_en[ch])
        begin
            t = (longint'(raw) * longint'(ref_mv)) / FULL_SCALE - OFFSET_TENTHS;
            if (t > TENTHS_MAX)
                t = TENTHS_MAX;
        end
        r.channel = 3'(ch);
        r.slot = slot;
        r.raw = raw;
        r.tenths = 19'(t);
        r.conv = chan_en[ch];
        r.header_ok = (chk_xor == CHECK_MAGIC);
        r.pad = pad;
        r.last = 1'b0;
        readings_due.push_back(r);
        slot = slot + 4'd1;
    endtask

    // Runs one accepted byte through the parser state.
    task automatic parse_byte(input logic [7:0] b, input logic eop);
        int       n0;
        int       off;
        logic     half;
        logic     skip;
        reading_t r;
        n0 = readings_due.size();
        half = 1'b0;
        if (byte_pos < HEADER_BYTES + BUFFER_BYTES)
        begin
            if (byte_pos == 0)
                first_word = {8'h00, b};
            else if (byte_pos == 1)
                first_word[15:8] = b;
            else if (byte_pos == 2)
                chk_xor = {8'h00, first_word[7:0] ^ b};
            else if (byte_pos == 3)
                chk_xor[15:8] = first_word[15:8] ^ b;
            else if (byte_pos == 9 || byte_pos == 10)
            begin
                if (b != 8'h00)
                    dig_present = 1'b1;
            end
            else if (byte_pos == 11)
            begin
                mask_left = b;
                slot = {3'b000, dig_present};
            end
            else if (byte_pos >= HEADER_BYTES)
            begin
                off = int'(byte_pos) - HEADER_BYTES;
                skip = 1'b0;
                if (dig_present)
                begin
                    if (off < 2)
                        skip = 1'b1;
                    else
                        off = off - 2;
                end
                if (!skip && mask_left != 0)
                begin
                    if (off % 2 == 0)
                    begin
                        hi_byte = b;
                        half = 1'b1;
                    end
                    else
                        emit_reading({hi_byte, b}, 1'b0);
                end
            end
            byte_pos = byte_pos + 6'd1;
        end

        // An early end flushes every pending channel with zero fill.
        if (eop)
        begin
            while (mask_left != 0)
            begin
                emit_reading(half ? {hi_byte, 8'h00} : 16'h0000, 1'b1);
                half = 1'b0;
            end
            byte_pos = '0;
            first_word = '0;
            chk_xor = '0;
            dig_present = 1'b0;
            mask_left = '0;
            hi_byte = '0;
            slot = '0;
        end

        if (readings_due.size() > n0)
        begin
            r = readings_due[readings_due.size() - 1];
            r.last = 1'b1;
            readings_due[readings_due.size() - 1] = r;
        end
    endtask

    // Sender: bursts of random length with random gaps in between.
    always @(posedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            if (push && !full)
            begin
                parse_byte(bytes_to_send[0].value, bytes_to_send[0].eop);
                bytes_to_send.delete(0);
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            if (gap_left > 0)
            begin
                push <= 1'b0;
                gap_left--;
            end
            else if (bytes_to_send.size() != 0)
            begin
                push <= 1'b1;
                packet_byte <= bytes_to_send[0].value;
                end_of_packet <= bytes_to_send[0].eop;
            end
            else
                push <= 1'b0;
        end
    end

    function automatic void check_field(input string name, input longint exp_v,
                                        input longint got_v);
        if (exp_v != got_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            mismatches++;
        end
    endfunction

    // Receiver: checks each accepted reading; pop follows a rotating pattern.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (readings_due.size() == 0)
            begin
                $error("reading with none due: channel %0d, raw %0d", channel, raw_value);
                mismatches++;
            end
            else
            begin
                due = readings_due.pop_front();
                check_field("channel", due.channel, channel);
                check_field("sample_slot", due.slot, sample_slot);
                check_field("raw_value", due.raw, raw_value);
                check_field("celsius_tenths", due.tenths, celsius_tenths);
                check_field("converted", due.conv, converted);
                check_field("header_ok", due.header_ok, header_ok);
                check_field("padded", due.pad, padded);
                check_field("last_of_run", due.last, last_of_run);
            end
        end
        if (pattern_left == 0)
        begin
            case ($urandom_range(0, 3))
                0: pop_pattern = 16'hFFFF;
                1: pop_pattern = 16'($urandom);
                2: pop_pattern = 16'h00FF;
                default: pop_pattern = 16'($urandom) | 16'($urandom);
            endcase
            pattern_left = 64;
        end
        pop <= pop_pattern[0];
        pop_pattern = {pop_pattern[0], pop_pattern[15:1]};
        pattern_left--;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    // Writes one register once the block takes it.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_CHANNEL_ENABLE)
            chan_en = data[7:0];
        else if (idx == CFG_REFERENCE_MV)
            ref_mv = data;
        cfg_valid <= 1'b0;
    endtask

    task automatic set_converter(input logic [7:0] en, input logic [12:0] mv);
        write_reg(CFG_CHANNEL_ENABLE, {5'($urandom), en});
        write_reg(CFG_REFERENCE_MV, mv);
    endtask

    // Waits until every byte is taken and every reading has come out.
    task automatic drain();
        do
            @(negedge clk);
        while (bytes_to_send.size() != 0 || push || readings_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic queue_packet(input logic [7:0] pkt[$]);
        packet_item_t it;
        foreach (pkt[i])
        begin
            it.value = pkt[i];
            it.eop = (i == pkt.size() - 1);
            bytes_to_send.push_back(it);
        end
        bytes_queued += pkt.size();
    endtask

    task automatic put_header(ref logic [7:0] pkt[$], input logic [15:0] w,
                              input logic good, input logic [7:0] d9,
                              input logic [7:0] d10, input logic [7:0] amask);
        pkt.push_back(w[7:0]);
        pkt.push_back(w[15:8]);
        pkt.push_back(good ? w[7:0] ^ CHECK_MAGIC[7:0] : 8'($urandom));
        pkt.push_back(good ? w[15:8] ^ CHECK_MAGIC[15:8] : 8'($urandom));
        repeat (5) pkt.push_back(8'($urandom));
        pkt.push_back(d9);
        pkt.push_back(d10);
        pkt.push_back(amask);
    endtask

    // A packet with random content: complete, cut short, or with trailing bytes.
    task automatic add_random_packet();
        logic [7:0]  pkt[$];
        logic [7:0]  d9;
        logic [7:0]  d10;
        logic [7:0]  amask;
        logic [15:0] s;
        int          sel;
        int          keep;
        d9 = 8'h00;
        d10 = 8'h00;
        sel = $urandom_range(0, 3);
        if (sel == 1)
            d9 = 8'($urandom_range(1, 255));
        else if (sel == 2)
            d10 = 8'($urandom_range(1, 255));
        else if (sel == 3)
        begin
            d9 = 8'($urandom);
            d10 = 8'($urandom);
        end
        sel = $urandom_range(0, 9);
        amask = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : 8'($urandom);
        put_header(pkt, 16'($urandom), $urandom_range(0, 4) != 0, d9, d10, amask);
        if ((d9 | d10) != 8'h00)
            repeat (2) pkt.push_back(8'($urandom));
        for (int i = 0; i < MAX_CHANNELS; i++)
        begin
            if (amask[i])
            begin
                sel = $urandom_range(0, 7);
                s = (sel == 0) ? 16'hFFFF : (sel == 1) ? 16'h0000 : 16'($urandom);
                pkt.push_back(s[15:8]);
                pkt.push_back(s[7:0]);
            end
        end
        sel = $urandom_range(0, 19);
        if (sel >= 11 && sel < 15)
        begin
            keep = $urandom_range(1, pkt.size());
            while (pkt.size() > keep)
                void'(pkt.pop_back());
        end
        else if (sel >= 15)
            repeat ($urandom_range(1, 24)) pkt.push_back(8'($urandom));
        queue_packet(pkt);
    endtask

    task automatic send_random(input int count);
        int target;
        target = bytes_queued + count;
        while (bytes_queued < target)
            add_random_packet();
        drain();
    endtask

    initial
    begin
        logic [7:0] pkt[$];
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings first.
        send_random(35);

        // Directed packets with every channel converted at full reference.
        set_converter(8'hFF, 13'd5000);
        // Packet that ends on its first byte.
        pkt = {8'hA5};
        queue_packet(pkt);
        // Good header, full-scale sample that saturates and a zero sample.
        pkt = {};
        put_header(pkt, 16'h1234, 1'b1, 8'h00, 8'h00, 8'h81);
        pkt.push_back(8'hFF);
        pkt.push_back(8'hFF);
        pkt.push_back(8'h00);
        pkt.push_back(8'h00);
        queue_packet(pkt);
        // Bad header, digital sample, end on a high byte.
        pkt = {};
        put_header(pkt, 16'hFFFF, 1'b0, 8'h00, 8'h80, 8'h05);
        pkt[2] = 8'hFF;
        pkt[3] = 8'hFF;
        pkt.push_back(8'h5A);
        pkt.push_back(8'hA5);
        pkt.push_back(8'hC3);
        queue_packet(pkt);
        drain();

        // Nothing converted, smallest reference.
        set_converter(8'h00, 13'd1);
        send_random(45);

        // Writes to unused indexes leave the settings alone.
        write_reg(2'd2, 13'($urandom));
        write_reg(2'd3, 13'($urandom));
        send_random(30);

        repeat (4)
        begin
            set_converter(8'($urandom), 13'($urandom_range(1, 5000)));
            send_random(40);
        end

        set_converter(8'hFF, 13'd5000);
        send_random(40);

        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
